// ===== rtl/splh_pkg.sv =====
// Shared types and constants of the slab point locate histogram core.
package splh_pkg;

   localparam int MAX_DIVIDERS_DEF = 4096;
   localparam int COORD_BITS_DEF   = 20;
   localparam int COUNT_BITS_DEF   = 20;

   localparam int CSR_INDEX_W = 2;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_SLOT = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_CLASSIFY = 2'd1,
      OP_READ     = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DIV_COUNT = 2'd0,
      CSR_LEFT_X    = 2'd1,
      CSR_TOP_Y     = 2'd2,
      CSR_BOTTOM_Y  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic capture;
      logic search_rd;
      logic search_mul;
      logic search_cmp;
      logic cnt_wr;
      logic clr_wr;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   read_bad;
      logic   search_more;
      logic   clr_last;
   } dp_sts_type;

endpackage

// ===== rtl/splh_ctrl.sv =====
// Sequencing state machine of the slab point locate histogram core.
module splh_ctrl
   import splh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_CLEAR    = 8'b0000_0001,
      ST_IDLE     = 8'b0000_0010,
      ST_SRCH_RD  = 8'b0000_0100,
      ST_SRCH_MUL = 8'b0000_1000,
      ST_SRCH_CMP = 8'b0001_0000,
      ST_CNT_RD   = 8'b0010_0000,
      ST_CNT_WR   = 8'b0100_0000,
      ST_RESP     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      respond_ff, respond_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_load;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      cmd            = '0;
      cmd.capture    = accept;
      cmd.search_rd  = (state_ff == ST_SRCH_RD) && sts.search_more;
      cmd.search_mul = (state_ff == ST_SRCH_MUL);
      cmd.search_cmp = (state_ff == ST_SRCH_CMP);
      cmd.cnt_wr     = (state_ff == ST_CNT_WR);
      cmd.clr_wr     = (state_ff == ST_CLEAR);
      cmd.out_load   = out_load;
   end

   always_comb begin
      state_in   = state_ff;
      respond_in = respond_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clr_last) begin
               state_in = respond_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (sts.op)
                  OP_LOAD:     state_in = ST_RESP;
                  OP_CLASSIFY: state_in = ST_SRCH_RD;
                  OP_READ:     state_in = sts.read_bad ? ST_RESP : ST_CNT_RD;
                  OP_CLEAR: begin
                     state_in   = ST_CLEAR;
                     respond_in = 1'b1;
                  end
                  default:     state_in = ST_RESP;
               endcase
            end
         end
         ST_SRCH_RD:  state_in = sts.search_more ? ST_SRCH_MUL : ST_CNT_RD;
         ST_SRCH_MUL: state_in = ST_SRCH_CMP;
         ST_SRCH_CMP: state_in = ST_SRCH_RD;
         ST_CNT_RD:   state_in = ST_CNT_WR;
         ST_CNT_WR:   state_in = ST_RESP;
         ST_RESP: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // The output register is refilled in the same cycle that its item is taken.
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         respond_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         respond_ff   <= respond_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/splh_datapath.sv =====
// Registers, memories and arithmetic of the slab point locate histogram core.
module splh_datapath
   import splh_pkg::*;
#(
   parameter int MAX_DIVIDERS = MAX_DIVIDERS_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF,
   parameter int COUNT_BITS   = COUNT_BITS_DEF,
   parameter int BIN_W        = $clog2(MAX_DIVIDERS + 1),
   parameter int CFG_W        = (BIN_W > COORD_BITS) ? BIN_W : COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dp_cmd_type                    cmd,
   output dp_sts_type                    sts,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]              csr_data,
   input  logic [1:0]                    req_operation,
   input  logic [BIN_W-1:0]              req_slot,
   input  logic signed [COORD_BITS-1:0]  req_coord_a,
   input  logic signed [COORD_BITS-1:0]  req_coord_b,
   output logic [BIN_W-1:0]              rsp_bin,
   output logic [COUNT_BITS-1:0]         rsp_count,
   output logic                          rsp_status
);

   localparam int AW        = (MAX_DIVIDERS > 1) ? $clog2(MAX_DIVIDERS) : 1;
   localparam int SW        = BIN_W + 1;
   localparam int DW        = COORD_BITS + 1;
   localparam int PW        = 2 * DW;
   localparam int CNT_DEPTH = MAX_DIVIDERS + 1;
   localparam logic [BIN_W-1:0]      MAX_BIN   = BIN_W'(MAX_DIVIDERS);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Configuration registers.
   logic [BIN_W-1:0]             div_count_ff, div_count_in;
   logic signed [COORD_BITS-1:0] left_x_ff, left_x_in;
   logic signed [COORD_BITS-1:0] top_y_ff, top_y_in;
   logic signed [COORD_BITS-1:0] bottom_y_ff, bottom_y_in;

   // Item and search registers.
   op_type                       op_ff, op_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in;
   logic signed [COORD_BITS-1:0] py_ff, py_in;
   logic [SW-1:0]                lo_ff, lo_in;
   logic [SW-1:0]                hi_ff, hi_in;
   logic [SW-1:0]                mid_ff, mid_in;
   logic                         wall_ff, wall_in;
   logic [BIN_W-1:0]             bin_ff, bin_in;
   logic signed [PW-1:0]         prod_a_ff, prod_a_in;
   logic signed [PW-1:0]         prod_b_ff, prod_b_in;
   logic [BIN_W-1:0]             clr_addr_ff, clr_addr_in;

   // Result held until the output register is free, and the output register.
   logic [BIN_W-1:0]             res_bin_ff, res_bin_in;
   logic [COUNT_BITS-1:0]        res_count_ff, res_count_in;
   logic                         res_status_ff, res_status_in;
   logic [BIN_W-1:0]             out_bin_ff, out_bin_in;
   logic [COUNT_BITS-1:0]        out_count_ff, out_count_in;
   logic                         out_status_ff, out_status_in;

   // Memories.
   logic [COORD_BITS-1:0]        top_mem [MAX_DIVIDERS];
   logic [COORD_BITS-1:0]        bot_mem [MAX_DIVIDERS];
   logic [COORD_BITS-1:0]        top_rd_ff;
   logic [COORD_BITS-1:0]        bot_rd_ff;
   logic [COUNT_BITS-1:0]        cnt_mem [CNT_DEPTH];
   logic [COUNT_BITS-1:0]        cnt_rd_ff;

   op_type                       req_op;
   logic                         load_bad;
   logic                         read_bad;
   logic [BIN_W-1:0]             n_eff;
   logic [SW:0]                  mid_sum;
   logic [SW-1:0]                mid_now;
   logic                         div_we;
   logic [AW-1:0]                div_wr_addr;
   logic [AW-1:0]                div_rd_addr;
   logic signed [COORD_BITS-1:0] sx;
   logic signed [COORD_BITS-1:0] ex;
   logic signed [DW-1:0]         dxa, dyb, dya, dxb;
   logic                         right_of;
   logic [COUNT_BITS-1:0]        cnt_inc;
   logic                         cnt_we;
   logic [BIN_W-1:0]             cnt_wr_addr;
   logic [COUNT_BITS-1:0]        cnt_wr_data;

   assign req_op   = op_type'(req_operation);
   assign load_bad = (req_slot == '0) || (req_slot > MAX_BIN);
   assign read_bad = (req_slot > MAX_BIN);
   assign n_eff    = (div_count_ff > MAX_BIN) ? MAX_BIN : div_count_ff;

   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_now     = mid_sum[SW:1];
   assign div_rd_addr = AW'(mid_now - SW'(2));

   assign div_we      = cmd.capture && (req_op == OP_LOAD) && !load_bad;
   assign div_wr_addr = AW'(req_slot - BIN_W'(1));

   // Line one is the left wall, a vertical line at left_x.
   assign sx  = wall_ff ? left_x_ff : $signed(top_rd_ff);
   assign ex  = wall_ff ? left_x_ff : $signed(bot_rd_ff);
   assign dxa = DW'(sx) - DW'(px_ff);
   assign dyb = DW'(bottom_y_ff) - DW'(py_ff);
   assign dya = DW'(top_y_ff) - DW'(py_ff);
   assign dxb = DW'(ex) - DW'(px_ff);
   assign prod_a_in = PW'(dxa) * PW'(dyb);
   assign prod_b_in = PW'(dya) * PW'(dxb);
   assign right_of  = (prod_a_ff > prod_b_ff);

   assign cnt_inc     = (cnt_rd_ff == COUNT_MAX) ? cnt_rd_ff : cnt_rd_ff + COUNT_BITS'(1);
   assign cnt_we      = cmd.clr_wr || (cmd.cnt_wr && (op_ff == OP_CLASSIFY));
   assign cnt_wr_addr = cmd.clr_wr ? clr_addr_ff : bin_ff;
   assign cnt_wr_data = cmd.clr_wr ? '0 : cnt_inc;

   always_comb begin
      sts             = '0;
      sts.op          = req_op;
      sts.read_bad    = read_bad;
      sts.search_more = (lo_ff <= hi_ff);
      sts.clr_last    = (clr_addr_ff == MAX_BIN);
   end

   always_comb begin
      div_count_in = div_count_ff;
      left_x_in    = left_x_ff;
      top_y_in     = top_y_ff;
      bottom_y_in  = bottom_y_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_DIV_COUNT: div_count_in = csr_data[BIN_W-1:0];
            CSR_LEFT_X:    left_x_in    = $signed(csr_data[COORD_BITS-1:0]);
            CSR_TOP_Y:     top_y_in     = $signed(csr_data[COORD_BITS-1:0]);
            CSR_BOTTOM_Y:  bottom_y_in  = $signed(csr_data[COORD_BITS-1:0]);
            default:       div_count_in = div_count_ff;
         endcase
      end
   end

   always_comb begin
      op_in         = op_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      wall_in       = wall_ff;
      bin_in        = bin_ff;
      clr_addr_in   = clr_addr_ff;
      res_bin_in    = res_bin_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;

      if (cmd.capture) begin
         op_in         = req_op;
         res_bin_in    = '0;
         res_count_in  = '0;
         res_status_in = STATUS_OK;
         unique case (req_op)
            OP_LOAD: begin
               res_status_in = load_bad ? STATUS_BAD_SLOT : STATUS_OK;
            end
            OP_CLASSIFY: begin
               px_in  = req_coord_a;
               py_in  = req_coord_b;
               lo_in  = SW'(1);
               hi_in  = SW'(n_eff) + SW'(1);
               bin_in = '0;
            end
            OP_READ: begin
               res_status_in = read_bad ? STATUS_BAD_SLOT : STATUS_OK;
               bin_in        = req_slot;
            end
            OP_CLEAR: begin
               clr_addr_in = '0;
            end
            default: begin
               bin_in = '0;
            end
         endcase
      end

      if (cmd.search_rd) begin
         mid_in  = mid_now;
         wall_in = (mid_now == SW'(1));
      end

      if (cmd.search_cmp) begin
         if (right_of) begin
            bin_in = BIN_W'(mid_ff - SW'(1));
            lo_in  = mid_ff + SW'(1);
         end else begin
            hi_in  = mid_ff - SW'(1);
         end
      end

      if (cmd.cnt_wr) begin
         res_bin_in    = bin_ff;
         res_count_in  = (op_ff == OP_CLASSIFY) ? cnt_inc : cnt_rd_ff;
         res_status_in = STATUS_OK;
      end

      if (cmd.clr_wr) begin
         clr_addr_in = clr_addr_ff + BIN_W'(1);
      end
   end

   always_comb begin
      out_bin_in    = out_bin_ff;
      out_count_in  = out_count_ff;
      out_status_in = out_status_ff;
      if (cmd.out_load) begin
         out_bin_in    = res_bin_ff;
         out_count_in  = res_count_ff;
         out_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_count_ff <= '0;
         left_x_ff    <= '0;
         top_y_ff     <= '0;
         bottom_y_ff  <= '0;
         clr_addr_ff  <= '0;
      end else begin
         div_count_ff <= div_count_in;
         left_x_ff    <= left_x_in;
         top_y_ff     <= top_y_in;
         bottom_y_ff  <= bottom_y_in;
         clr_addr_ff  <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      wall_ff       <= wall_in;
      bin_ff        <= bin_in;
      res_bin_ff    <= res_bin_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      out_bin_ff    <= out_bin_in;
      out_count_ff  <= out_count_in;
      out_status_ff <= out_status_in;
      if (cmd.search_mul) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_we) begin
         top_mem[div_wr_addr] <= req_coord_a;
         bot_mem[div_wr_addr] <= req_coord_b;
      end
      top_rd_ff <= top_mem[div_rd_addr];
      bot_rd_ff <= bot_mem[div_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wr_addr] <= cnt_wr_data;
      end
      cnt_rd_ff <= cnt_mem[bin_ff];
   end

   assign rsp_bin    = out_bin_ff;
   assign rsp_count  = out_count_ff;
   assign rsp_status = out_status_ff;

endmodule

// ===== rtl/slab_point_locate_histogram_core.sv =====
// Top level of the slab point locate histogram core.
//
//   channel   direction   handshake                 payload
//   req_      in          req_valid / req_stall     operation, slot, coord_a, coord_b
//   rsp_      out         rsp_valid / rsp_stall     bin, count, status
//   csr_      in          csr_write                 csr_index, csr_data
//
// One item is worked on at a time. A classify runs at most S search steps, where
// S = floor(log2(N + 1)) + 1, and each step is a divider memory read, a multiply pair and
// a compare. A clear sweeps the count memory one entry a cycle. After reset the same sweep
// runs with req_stall high. The output register lets the next item be accepted while a
// result waits on rsp_stall.
module slab_point_locate_histogram_core
   import splh_pkg::*;
#(
   parameter int MAX_DIVIDERS = MAX_DIVIDERS_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF,
   parameter int COUNT_BITS   = COUNT_BITS_DEF,
   parameter int BIN_W        = $clog2(MAX_DIVIDERS + 1),
   parameter int CFG_W        = (BIN_W > COORD_BITS) ? BIN_W : COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]              csr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_operation,
   input  logic [BIN_W-1:0]              req_slot,
   input  logic signed [COORD_BITS-1:0]  req_coord_a,
   input  logic signed [COORD_BITS-1:0]  req_coord_b,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [BIN_W-1:0]              rsp_bin,
   output logic [COUNT_BITS-1:0]         rsp_count,
   output logic                          rsp_status
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   splh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   splh_datapath #(
      .MAX_DIVIDERS (MAX_DIVIDERS),
      .COORD_BITS   (COORD_BITS),
      .COUNT_BITS   (COUNT_BITS),
      .BIN_W        (BIN_W),
      .CFG_W        (CFG_W)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_operation (req_operation),
      .req_slot      (req_slot),
      .req_coord_a   (req_coord_a),
      .req_coord_b   (req_coord_b),
      .rsp_bin       (rsp_bin),
      .rsp_count     (rsp_count),
      .rsp_status    (rsp_status)
   );

   // A rejected slot never reports a bin or a count.
   a_bad_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_BAD_SLOT) |-> (rsp_bin == '0 && rsp_count == '0))
      else $error("bad slot result carries a bin or count");

   // Every accepted item is worked on alone.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while another is in work");

   // No bin beyond the last one is ever reported.
   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bin <= BIN_W'(MAX_DIVIDERS)))
      else $error("bin out of range");

   // The block comes out of reset busy with the count sweep.
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> (req_stall && !rsp_valid))
      else $error("block ready straight after reset");

endmodule

// ===== tb/slab_point_locate_histogram_core_test.sv =====
// Self-checking testbench for the slab point locate histogram core.
`timescale 1ns / 1ps

module slab_point_locate_histogram_core_test;
   import splh_pkg::*;

   localparam int     MAXD = MAX_DIVIDERS_DEF;
   localparam int     CW   = COORD_BITS_DEF;
   localparam int     NW   = COUNT_BITS_DEF;
   localparam int     BW   = $clog2(MAXD + 1);
   localparam int     DW   = (BW > CW) ? BW : CW;
   localparam longint XMAX = (longint'(1) << (CW - 1)) - 1;
   localparam longint XMIN = -XMAX - 1;
   localparam int     SLOT_TOP = (1 << BW) - 1;

   typedef struct packed {
      logic [BW-1:0] bin;
      logic [NW-1:0] count;
      logic          status;
   } bin_tally;

   class histogram_tracker;
      logic [BW-1:0]        div_count;
      logic signed [CW-1:0] wall_x;
      logic signed [CW-1:0] upper_y;
      logic signed [CW-1:0] lower_y;
      logic signed [CW-1:0] div_top [MAXD];
      logic signed [CW-1:0] div_bottom [MAXD];
      bit                   in_layout [MAXD];
      logic [NW-1:0]        tallies [MAXD + 1];
      bin_tally             bin_tallies [$];
      int                   errors;

      function new();
         div_count = '0;
         wall_x    = '0;
         upper_y   = '0;
         lower_y   = '0;
         errors    = 0;
         foreach (div_top[k]) begin
            div_top[k]    = '0;
            div_bottom[k] = '0;
            in_layout[k]  = 1'b0;
         end
         foreach (tallies[k]) tallies[k] = '0;
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function void write_register(csr_index_type idx, logic [DW-1:0] data);
         case (idx)
            CSR_DIV_COUNT: div_count = data[BW-1:0];
            CSR_LEFT_X:    wall_x    = data[CW-1:0];
            CSR_TOP_Y:     upper_y   = data[CW-1:0];
            default:       lower_y   = data[CW-1:0];
         endcase
      endfunction

      // A new layout starts: every divider has to be loaded again before a search may use it.
      function void start_layout();
         foreach (in_layout[k]) in_layout[k] = 1'b0;
      endfunction

      function bit strictly_right(longint px, longint py, longint sx, longint sy,
                                  longint ex, longint ey);
         return (sx - px) * (ey - py) > (sy - py) * (ex - px);
      endfunction

      // Binary search for the rightmost line the point lies strictly right of. Hole is the
      // first divider on the search path that has not been loaded in this layout, or 0.
      function int walk_lines(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                              output int hole);
         int     n;
         int     lo;
         int     hi;
         int     mid;
         int     found;
         longint sx;
         longint ex;
         n     = (div_count > MAXD) ? MAXD : int'(div_count);
         lo    = 1;
         hi    = n + 1;
         found = 1;
         hole  = 0;
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (mid == 1) begin
               sx = longint'(wall_x);
               ex = longint'(wall_x);
            end else begin
               if (!in_layout[mid - 2] && hole == 0) hole = mid - 1;
               sx = longint'(div_top[mid - 2]);
               ex = longint'(div_bottom[mid - 2]);
            end
            if (strictly_right(longint'(px), longint'(py), sx, longint'(upper_y),
                               ex, longint'(lower_y))) begin
               found = mid;
               lo    = mid + 1;
            end else begin
               hi = mid - 1;
            end
         end
         return found;
      endfunction

      function void note_request(op_type op, logic [BW-1:0] slot,
                                 logic signed [CW-1:0] a, logic signed [CW-1:0] b);
         bin_tally want;
         int       hole;
         int       idx;
         want = '{default: '0};
         want.status = STATUS_OK;
         case (op)
            OP_LOAD: begin
               if (slot == 0 || slot > MAXD) begin
                  want.status = STATUS_BAD_SLOT;
               end else begin
                  div_top[slot - 1]    = a;
                  div_bottom[slot - 1] = b;
                  in_layout[slot - 1]  = 1'b1;
               end
            end
            OP_CLASSIFY: begin
               idx = walk_lines(a, b, hole) - 1;
               if (tallies[idx] != '1) tallies[idx] = tallies[idx] + NW'(1);
               want.bin   = idx[BW-1:0];
               want.count = tallies[idx];
            end
            OP_READ: begin
               if (slot > MAXD) begin
                  want.status = STATUS_BAD_SLOT;
               end else begin
                  want.bin   = slot;
                  want.count = tallies[slot];
               end
            end
            default: begin
               foreach (tallies[k]) tallies[k] = '0;
            end
         endcase
         bin_tallies.push_back(want);
      endfunction

      task check_result(logic [BW-1:0] bin, logic [NW-1:0] count, logic status);
         bin_tally want;
         if (bin_tallies.size() == 0) begin
            report($sformatf("result bin %0d count %0d status %0d with nothing outstanding",
                             bin, count, status));
            return;
         end
         want = bin_tallies.pop_front();
         if (bin !== want.bin)
            report($sformatf("bin %0d, expected %0d", bin, want.bin));
         if (count !== want.count)
            report($sformatf("count %0d, expected %0d (bin %0d)", count, want.count, want.bin));
         if (status !== want.status)
            report($sformatf("status %0d, expected %0d", status, want.status));
      endtask

      function int pending();
         return bin_tallies.size();
      endfunction
   endclass

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 csr_write     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [DW-1:0]        csr_data      = '0;
   logic                 req_valid     = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_operation = '0;
   logic [BW-1:0]        req_slot      = '0;
   logic signed [CW-1:0] req_coord_a   = '0;
   logic signed [CW-1:0] req_coord_b   = '0;
   logic                 rsp_valid;
   logic                 rsp_stall     = 1'b0;
   logic [BW-1:0]        rsp_bin;
   logic [NW-1:0]        rsp_count;
   logic                 rsp_status;

   histogram_tracker tracker;
   bit               steady      = 1'b0;
   int               hold_cycles = 0;
   int               lanes       = 0;
   longint           cur_left;
   longint           cur_top;
   longint           cur_bottom;
   longint           plan_top [1:MAXD];
   longint           plan_bottom [1:MAXD];

   slab_point_locate_histogram_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_slot      (req_slot),
      .req_coord_a   (req_coord_a),
      .req_coord_b   (req_coord_b),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_bin       (rsp_bin),
      .rsp_count     (rsp_count),
      .rsp_status    (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("slab_point_locate_histogram_core_test failed");
      $finish;
   end

   // Result side: after each accepted result the receiver holds off at random, except in steady mode.
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         tracker.check_result(rsp_bin, rsp_count, rsp_status);
         hold_cycles = steady ? 0 : $urandom_range(0, 7);
      end else if (hold_cycles > 0) begin
         hold_cycles--;
      end
      rsp_stall <= (hold_cycles > 0);
   end

   function automatic longint fit_coord(longint v);
      if (v > XMAX) return XMAX;
      if (v < XMIN) return XMIN;
      return v;
   endfunction

   function automatic longint rand_coord();
      logic signed [CW-1:0] v;
      v = CW'($urandom);
      return longint'(v);
   endfunction

   task automatic send_item(op_type op, int slot, longint a, longint b);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_slot      <= slot[BW-1:0];
      req_coord_a   <= a[CW-1:0];
      req_coord_b   <= b[CW-1:0];
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.note_request(op, slot[BW-1:0], a[CW-1:0], b[CW-1:0]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   task automatic set_register(csr_index_type idx, longint value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[DW-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      tracker.write_register(idx, value[DW-1:0]);
   endtask

   // Writes all four registers once the block is idle and lays out an ordered set of dividers
   // spread across the box, each with a little jitter that keeps the order intact.
   task automatic configure(int count, longint left, longint top, longint bottom);
      longint step_t;
      longint step_b;
      drain();
      set_register(CSR_DIV_COUNT, (longint'($urandom_range(0, 127)) << BW) | longint'(count));
      set_register(CSR_LEFT_X, left);
      set_register(CSR_TOP_Y, top);
      set_register(CSR_BOTTOM_Y, bottom);
      lanes      = (count > MAXD) ? MAXD : count;
      cur_left   = left;
      cur_top    = top;
      cur_bottom = bottom;
      step_t     = (XMAX - left) / longint'(lanes + 1);
      step_b     = step_t * longint'($urandom_range(60, 100)) / 100;
      for (int k = 1; k <= MAXD; k++) begin
         plan_top[k]    = fit_coord(left + longint'(k) * step_t +
                                    longint'($urandom_range(0, int'(step_t / 3))));
         plan_bottom[k] = fit_coord(left + longint'(k) * step_b +
                                    longint'($urandom_range(0, int'(step_b / 3))));
      end
      tracker.start_layout();
   endtask

   // Loads whatever dividers the search would touch before it is safe to classify the point.
   task automatic locate_point(longint x, longint y);
      int hole;
      void'(tracker.walk_lines(x[CW-1:0], y[CW-1:0], hole));
      while (hole != 0) begin
         send_item(OP_LOAD, hole, plan_top[hole], plan_bottom[hole]);
         void'(tracker.walk_lines(x[CW-1:0], y[CW-1:0], hole));
      end
      send_item(OP_CLASSIFY, $urandom_range(0, SLOT_TOP), x, y);
   endtask

   task automatic directed_items();
      // With the registers at reset every line collapses to a point, so the item goes to bin 0.
      send_item(OP_CLASSIFY, 0, 0, 0);
      configure(4, -1000, 1000, -1000);
      send_item(OP_LOAD, 0, XMAX, XMIN);
      send_item(OP_LOAD, MAXD + 1, XMIN, XMAX);
      send_item(OP_LOAD, SLOT_TOP, -1, -1);
      for (int k = 1; k <= 4; k++)
         send_item(OP_LOAD, k, -1000 + 400 * k, -900 + 400 * k);
      send_item(OP_CLASSIFY, 0, -1000, 0);
      send_item(OP_CLASSIFY, 1, XMIN, XMAX);
      send_item(OP_CLASSIFY, 2, -800, 0);
      send_item(OP_CLASSIFY, 3, 0, 0);
      // This point sits exactly on the third divider, which does not count as right of it.
      send_item(OP_CLASSIFY, 4, 200, 1000);
      send_item(OP_CLASSIFY, SLOT_TOP, XMAX, XMIN);
      send_item(OP_READ, 0, 0, 0);
      send_item(OP_READ, 2, XMAX, XMAX);
      send_item(OP_READ, MAXD, 0, 0);
      send_item(OP_READ, MAXD + 1, 0, 0);
      send_item(OP_READ, SLOT_TOP, XMIN, XMIN);
      send_item(OP_CLEAR, SLOT_TOP, XMIN, XMAX);
      send_item(OP_READ, 2, 0, 0);
   endtask

   task automatic random_items(int items);
      int     pick;
      int     k;
      longint lo_y;
      longint hi_y;
      longint x;
      longint y;
      lo_y = (cur_top < cur_bottom) ? cur_top : cur_bottom;
      hi_y = (cur_top < cur_bottom) ? cur_bottom : cur_top;
      for (int i = 0; i < items; i++) begin
         if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
         if (i == items / 2) drain();
         pick = $urandom_range(0, 99);
         y = lo_y + longint'($urandom_range(0, int'(hi_y - lo_y)));
         x = fit_coord(cur_left - 64 + longint'($urandom_range(0, int'(XMAX - cur_left) + 64)));
         if (pick < 35 || (pick >= 92 && pick < 99)) begin
            locate_point(x, y);
         end else if (pick < 42) begin
            // Points placed exactly on the wall or on a divider end.
            k = $urandom_range(0, lanes);
            if (k == 0)
               locate_point(cur_left, y);
            else if ($urandom_range(0, 1) == 0)
               locate_point(plan_top[k], cur_top);
            else
               locate_point(plan_bottom[k], cur_bottom);
         end else if (pick < 50) begin
            locate_point(rand_coord(), rand_coord());
         end else if (pick < 65) begin
            send_item(OP_READ, $urandom_range(0, lanes), rand_coord(), rand_coord());
         end else if (pick < 70) begin
            send_item(OP_READ, $urandom_range(0, SLOT_TOP), rand_coord(), rand_coord());
         end else if (pick < 85) begin
            k = $urandom_range(1, (lanes > 0) ? lanes : 1);
            send_item(OP_LOAD, k, plan_top[k], plan_bottom[k]);
         end else if (pick < 89) begin
            send_item(OP_LOAD, $urandom_range(0, SLOT_TOP), rand_coord(), rand_coord());
         end else if (pick < 92) begin
            // A crossed divider inside the layout; the search must still follow it faithfully.
            send_item(OP_LOAD, $urandom_range(1, (lanes > 0) ? lanes : 1),
                      rand_coord(), rand_coord());
         end else begin
            send_item(OP_CLEAR, $urandom_range(0, SLOT_TOP), rand_coord(), rand_coord());
         end
      end
   endtask

   // Large layouts pull in many divider loads ahead of their points, so they get fewer items.
   initial begin
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // The count memory is swept after reset; wait until the block takes items.
      do @(posedge clock); while (req_stall !== 1'b0);
      directed_items();
      configure(8, -3000, 5000, -5000);
      random_items(200);
      configure(MAXD, XMIN, XMAX, XMIN);
      random_items(40);
      configure(SLOT_TOP, rand_coord(), rand_coord(), rand_coord());
      random_items(40);
      configure(0, XMAX, XMIN, XMAX);
      random_items(80);
      configure(1, 0, 123, 123);
      random_items(80);
      configure($urandom_range(2, 300), rand_coord(), rand_coord(), rand_coord());
      random_items(150);
      drain();
      repeat (64) @(posedge clock);
      if (tracker.errors == 0)
         $display("slab_point_locate_histogram_core_test passed");
      else
         $display("slab_point_locate_histogram_core_test failed");
      $finish;
   end

endmodule
